// ===== rtl/core/wgm_pkg.sv =====
package wgm_pkg;

	localparam int MAX_PATTERN = 32;
	localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
	localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int SYM_W       = 8;
	localparam int OP_W        = 2;

	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OP_W-1:0] OP_TEXT   = 2'd2;
	localparam logic [OP_W-1:0] OP_END    = 2'd3;

	localparam logic [SYM_W-1:0] CH_ANY_ONE = 8'h3F;
	localparam logic [SYM_W-1:0] CH_ANY_RUN = 8'h2A;

	typedef struct packed {
		logic             is_clear;
		logic             is_append;
		logic             is_text;
		logic             is_end;
		logic [SYM_W-1:0] sym;
	} item_t;

endpackage

// ===== rtl/core/wildcard_glob_matcher.sv =====
// Result path: an end-of-text beat goes through the front-end queue into the result register.
// Throughput: one beat per cycle while stall is low, fed by a two-entry queue; each text byte
// advances the position set through one compare bank and one star-closure add in the back end.
// Reset: clears pattern length, overflow flag, queue and result-valid flag, and puts the active set at its start;
// the pattern store and matched/overflow outputs are not cleared; the store is only read below the pattern length.
module wildcard_glob_matcher (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid,
	output logic                      stall,
	input  logic [wgm_pkg::OP_W-1:0]  operation,
	input  logic [wgm_pkg::SYM_W-1:0] symbol,
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic                      matched,
	output logic                      overflow
);
	import wgm_pkg::*;

	item_t item;
	logic  item_valid;
	logic  item_take;

	wgm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (valid),
		.stall      (stall),
		.operation  (operation),
		.symbol     (symbol),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take)
	);

	wgm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item         (item),
		.item_take    (item_take),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.matched      (matched),
		.overflow     (overflow)
	);

endmodule

// ===== rtl/core/wgm_front.sv =====
module wgm_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid,
	output logic                        stall,
	input  logic [wgm_pkg::OP_W-1:0]    operation,
	input  logic [wgm_pkg::SYM_W-1:0]   symbol,
	output logic                        item_valid,
	output wgm_pkg::item_t              item,
	input  logic                        item_take
);
	import wgm_pkg::*;

	localparam int QDEPTH = 2;

	item_t      q_mem [QDEPTH];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	item_t      cls;
	logic       push;
	logic       pop;

	// classify the incoming beat
	always_comb begin
		cls           = '0;
		cls.sym       = symbol;
		cls.is_clear  = (operation == OP_CLEAR);
		cls.is_append = (operation == OP_APPEND);
		cls.is_text   = (operation == OP_TEXT);
		cls.is_end    = (operation == OP_END);
	end

	assign stall      = (cnt_q == 2'(QDEPTH));
	assign push       = valid && !stall;
	assign item_valid = (cnt_q != 2'd0);
	assign pop        = item_take && item_valid;
	assign item       = q_mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/wgm_back.sv =====
module wgm_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  wgm_pkg::item_t item,
	output logic           item_take,
	output logic           result_valid,
	input  logic           result_stall,
	output logic           matched,
	output logic           overflow
);
	import wgm_pkg::*;

	logic [SYM_W-1:0]       pat_q [MAX_PATTERN];
	logic [LEN_W-1:0]       len_q;
	logic [MAX_PATTERN-1:0] vmask_q;
	logic [MAX_PATTERN:0]   act_q;
	logic                   ovf_q;
	logic                   res_valid_q;
	logic                   matched_q;
	logic                   overflow_q;

	logic [MAX_PATTERN-1:0] star;
	logic [MAX_PATTERN-1:0] hit;
	logic [MAX_PATTERN:0]   sum;
	logic [MAX_PATTERN:0]   closed;
	logic [MAX_PATTERN:0]   nxt;
	logic                   out_free;
	logic                   full;

	always_comb begin
		for (int p = 0; p < MAX_PATTERN; p++) begin
			star[p] = vmask_q[p] && (pat_q[p] == CH_ANY_RUN);
			hit[p]  = vmask_q[p] && !star[p]
				&& ((pat_q[p] == CH_ANY_ONE) || (pat_q[p] == item.sym));
		end
	end

	// star closure: carries ripple through runs of stars from each active star
	assign sum    = {1'b0, act_q[MAX_PATTERN-1:0] & star} + {1'b0, star};
	assign closed = act_q | (sum ^ {1'b0, star});
	assign nxt    = {1'b0, closed[MAX_PATTERN-1:0] & star}
		| {closed[MAX_PATTERN-1:0] & hit, 1'b0};

	assign full      = (len_q == LEN_W'(MAX_PATTERN));
	assign out_free  = !res_valid_q || !result_stall;
	assign item_take = item_valid && (!item.is_end || out_free);

	always_ff @(posedge clk) begin
		if (item_take && item.is_append && !full) begin
			pat_q[len_q[IDX_W-1:0]] <= item.sym;
		end
		if (item_take && item.is_end) begin
			matched_q  <= closed[len_q];
			overflow_q <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			vmask_q     <= '0;
			act_q       <= (MAX_PATTERN + 1)'(1);
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (item_take) begin
				priority if (item.is_clear) begin
					len_q   <= '0;
					vmask_q <= '0;
					ovf_q   <= 1'b0;
					act_q   <= (MAX_PATTERN + 1)'(1);
				end else if (item.is_append) begin
					if (!full) begin
						len_q                      <= len_q + LEN_W'(1);
						vmask_q[len_q[IDX_W-1:0]] <= 1'b1;
					end else begin
						ovf_q <= 1'b1;
					end
					act_q <= (MAX_PATTERN + 1)'(1);
				end else if (item.is_text) begin
					act_q <= nxt;
				end else begin
					act_q <= (MAX_PATTERN + 1)'(1);
				end
			end
			if (item_take && item.is_end) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign matched      = matched_q;
	assign overflow     = overflow_q;

endmodule
